[hdl/plst_pkg.sv]
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and codes for the positional list engine.
// ----------------------------------------------------------------------------
package plst_pkg;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_FIND     = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_DUMP_FWD = 3'd4,
    OP_DUMP_REV = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_LOW      = 3'd1,
    STAT_BEYOND   = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_NOTFOUND = 3'd4,
    STAT_FULL     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_FIND,
    S_DUMP,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t            status;
    logic [5:0]         fpos;
    logic signed [31:0] value;
    logic [5:0]         count;
    logic               last;
  } resp_t;

endpackage

[hdl/positional_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of signed 32-bit values with 1-based positions: insert,
// delete, find, clear and forward/reverse dump, held in a single RAM.
// ----------------------------------------------------------------------------
//  channel | direction | tdata fields (low to high)                | tlast
//  in_     | slave     | op, position, item_value                  | -
//  out_    | master    | status, found_position, out_value, count  | last
//
//  Insert shifts entries at and after the position up, then writes the value
//  (appending writes at once); delete shifts later entries down (none when the
//  tail goes); find scans from the front; clear and rejections respond directly.
//  Entries move one per cycle through the single RAM read/write port pair.
//  Reset clears the count and FSM, not the RAM. A result waits in the output
//  register while the next transaction is taken; a stalled output holds a dump.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op[2:0], position[8:3], item_value[40:9]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[2:0], found_position[8:3],
                                  // out_value[40:9], entry_count[46:41]
  output logic        out_tlast
);

  import plst_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata, mem_rdata;
  logic          slot_free, push;
  resp_t         push_data, out_data;

  plst_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (op_t'(in_tdata[2:0])),
    .in_pos    (in_tdata[8:3]),
    .in_val    (in_tdata[40:9]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .slot_free (slot_free),
    .push      (push),
    .push_data (push_data)
  );

  plst_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  plst_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .slot_free (slot_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_data)
  );

  assign out_tdata = {1'b0, out_data.count, out_data.value, out_data.fpos,
                      out_data.status};
  assign out_tlast = out_data.last;

endmodule

[hdl/plst_mem.sv]
// ----------------------------------------------------------------------------
// plst_mem
// Element store: one write port, one registered read port with enable.
// ----------------------------------------------------------------------------
module plst_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [31:0]       wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [31:0]       rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/plst_out.sv]
// ----------------------------------------------------------------------------
// plst_out
// Result output register; frees its slot in the cycle it is taken.
// ----------------------------------------------------------------------------
module plst_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  plst_pkg::resp_t push_data,
  output logic            slot_free,
  output logic            out_valid,
  input  logic            out_ready,
  output plst_pkg::resp_t out_data
);

  import plst_pkg::*;

  logic  valid_r, valid_nxt;
  resp_t data_r;

  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[hdl/plst_ctrl.sv]
// ----------------------------------------------------------------------------
// plst_ctrl
// Sequencer: decodes operations, walks the store for shifts, search and
// dumps, and keeps the element count.
// ----------------------------------------------------------------------------
module plst_ctrl #(
  parameter int CAPACITY = 32,
  parameter int AW       = 5,
  parameter int CW       = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  plst_pkg::op_t         in_op,
  input  logic [5:0]            in_pos,
  input  logic [31:0]           in_val,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [31:0]           mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [31:0]           mem_rdata,
  input  logic                  slot_free,
  output logic                  push,
  output plst_pkg::resp_t       push_data
);

  import plst_pkg::*;

  localparam int PW = ((CW > 6) ? CW : 6) + 1;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  op_t           op_r, op_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [AW-1:0] stop_r, stop_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic [AW-1:0] p_idx_r, p_idx_nxt;
  logic [AW-1:0] chk_idx_r, chk_idx_nxt;
  logic          pend_r, pend_nxt;
  logic          chk_r, chk_nxt;
  logic          rd_done_r, rd_done_nxt;
  logic          pv_r, pv_nxt;
  logic          lastp_r, lastp_nxt;
  status_t       status_r, status_nxt;
  logic [5:0]    fpos_r, fpos_nxt;

  logic [PW-1:0] pos_e, cnt_e;
  logic [AW-1:0] cnt_m1;
  logic          issue, load;

  assign pos_e  = PW'(in_pos);
  assign cnt_e  = PW'(count_r);
  assign cnt_m1 = AW'(count_r - CW'(1));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    rd_idx_nxt  = rd_idx_r;
    stop_nxt    = stop_r;
    wa_nxt      = wa_r;
    p_idx_nxt   = p_idx_r;
    chk_idx_nxt = chk_idx_r;
    pend_nxt    = pend_r;
    chk_nxt     = chk_r;
    rd_done_nxt = rd_done_r;
    pv_nxt      = pv_r;
    lastp_nxt   = lastp_r;
    status_nxt  = status_r;
    fpos_nxt    = fpos_r;
    in_ready    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = wa_r;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = rd_idx_r;
    push        = 1'b0;
    push_data   = '{status: STAT_OK, fpos: 6'd0, value: 32'sd0,
                    count: 6'(count_r), last: 1'b1};
    issue       = 1'b0;
    load        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt      = in_op;
          val_nxt     = in_val;
          fpos_nxt    = 6'd0;
          status_nxt  = STAT_OK;
          pend_nxt    = 1'b0;
          chk_nxt     = 1'b0;
          pv_nxt      = 1'b0;
          rd_done_nxt = 1'b0;
          p_idx_nxt   = AW'(pos_e - PW'(1));
          unique case (in_op)
            OP_INSERT: begin
              priority if (pos_e == '0) begin
                status_nxt = STAT_LOW;
                state_nxt  = S_RESP;
              end else if (cnt_e == PW'(CAPACITY)) begin
                status_nxt = STAT_FULL;
                state_nxt  = S_RESP;
              end else if (pos_e > cnt_e + PW'(1)) begin
                status_nxt = STAT_BEYOND;
                state_nxt  = S_RESP;
              end else if (pos_e == cnt_e + PW'(1)) begin
                state_nxt = S_PUT;
              end else begin
                rd_idx_nxt = cnt_m1;
                stop_nxt   = AW'(pos_e - PW'(1));
                state_nxt  = S_SHIFT;
              end
            end
            OP_DELETE: begin
              priority if (pos_e == '0) begin
                status_nxt = STAT_LOW;
                state_nxt  = S_RESP;
              end else if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
                state_nxt  = S_RESP;
              end else if (pos_e > cnt_e) begin
                status_nxt = STAT_BEYOND;
                state_nxt  = S_RESP;
              end else if (pos_e == cnt_e) begin
                count_nxt = count_r - CW'(1);
                state_nxt = S_RESP;
              end else begin
                rd_idx_nxt = AW'(pos_e);
                stop_nxt   = cnt_m1;
                state_nxt  = S_SHIFT;
              end
            end
            OP_FIND: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                rd_idx_nxt = '0;
                state_nxt  = S_FIND;
              end
            end
            OP_CLEAR: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                count_nxt = '0;
              end
              state_nxt = S_RESP;
            end
            OP_DUMP_FWD, OP_DUMP_REV: begin
              if (count_r == '0) begin
                status_nxt = STAT_EMPTY;
                state_nxt  = S_RESP;
              end else begin
                rd_idx_nxt = (in_op == OP_DUMP_FWD) ? '0 : cnt_m1;
                stop_nxt   = (in_op == OP_DUMP_FWD) ? cnt_m1 : '0;
                state_nxt  = S_DUMP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SHIFT: begin
        mem_re   = 1'b1;
        mem_we   = pend_r;
        pend_nxt = 1'b1;
        wa_nxt   = (op_r == OP_INSERT) ? rd_idx_r + AW'(1) : rd_idx_r - AW'(1);
        if (rd_idx_r == stop_r) begin
          state_nxt = S_DRAIN;
        end else begin
          rd_idx_nxt = (op_r == OP_INSERT) ? rd_idx_r - AW'(1) : rd_idx_r + AW'(1);
        end
      end

      S_DRAIN: begin
        mem_we   = 1'b1;
        pend_nxt = 1'b0;
        if (op_r == OP_INSERT) begin
          state_nxt = S_PUT;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = p_idx_r;
        mem_wdata = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_RESP;
      end

      S_FIND: begin
        if (!rd_done_r) begin
          mem_re      = 1'b1;
          chk_nxt     = 1'b1;
          chk_idx_nxt = rd_idx_r;
          if (rd_idx_r == cnt_m1) begin
            rd_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
        end
        if (chk_r) begin
          priority if (mem_rdata == val_r) begin
            mem_re     = 1'b0;
            fpos_nxt   = 6'(chk_idx_r + AW'(1)) | ((chk_idx_r == '1) ? 6'(CAPACITY) : 6'd0);
            status_nxt = STAT_OK;
            state_nxt  = S_RESP;
          end else if (chk_idx_r == cnt_m1) begin
            status_nxt = STAT_NOTFOUND;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end

      S_DUMP: begin
        load  = pv_r && slot_free;
        issue = !rd_done_r && (!pv_r || load);
        if (load) begin
          push            = 1'b1;
          push_data.value = mem_rdata;
          push_data.last  = lastp_r;
          if (lastp_r) begin
            state_nxt = S_IDLE;
          end
        end
        if (issue) begin
          mem_re    = 1'b1;
          pv_nxt    = 1'b1;
          lastp_nxt = (rd_idx_r == stop_r);
          if (rd_idx_r == stop_r) begin
            rd_done_nxt = 1'b1;
          end else begin
            rd_idx_nxt = (op_r == OP_DUMP_FWD) ? rd_idx_r + AW'(1) : rd_idx_r - AW'(1);
          end
        end else if (load) begin
          pv_nxt = 1'b0;
        end
      end

      S_RESP: begin
        if (slot_free) begin
          push             = 1'b1;
          push_data.status = status_r;
          push_data.fpos   = fpos_r;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      pend_r    <= 1'b0;
      chk_r     <= 1'b0;
      rd_done_r <= 1'b0;
      pv_r      <= 1'b0;
      lastp_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      pend_r    <= pend_nxt;
      chk_r     <= chk_nxt;
      rd_done_r <= rd_done_nxt;
      pv_r      <= pv_nxt;
      lastp_r   <= lastp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    rd_idx_r  <= rd_idx_nxt;
    stop_r    <= stop_nxt;
    wa_r      <= wa_nxt;
    p_idx_r   <= p_idx_nxt;
    chk_idx_r <= chk_idx_nxt;
    status_r  <= status_nxt;
    fpos_r    <= fpos_nxt;
  end

endmodule
